>>> rtl/core/sjq_pkg.sv
// Package for the sorted priority job queue: operation codes and transaction payload types.
package sjq_pkg;

  localparam int unsigned IdW      = 16;
  localparam int unsigned PriPortW = 8;
  localparam int unsigned CntPortW = 5;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic signed [IdW-1:0]      job_id;
    logic [PriPortW-1:0]        job_priority;
  } req_t;

  typedef struct packed {
    logic                       job_valid;
    logic signed [IdW-1:0]      out_id;
    logic [PriPortW-1:0]        out_priority;
    logic                       accepted;
    logic [CntPortW-1:0]        entry_count;
    logic [CntPortW-1:0]        space_left;
    logic                       is_full;
    logic                       is_empty;
  } rsp_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

>>> rtl/core/sjq_if.sv
// Valid/ready channel interfaces for queue requests and responses.
interface sjq_req_if;
  import sjq_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sjq_rsp_if;
  import sjq_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/sjq_cell.sv
// One slot of the sorted chain: holds a job and shifts with its neighbours.
module sjq_cell #(
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                          clk_i,
  input  sjq_pkg::cell_ctrl_t           ctrl_i,
  input  logic                          occ_i,
  input  logic [sjq_pkg::IdW-1:0]       new_id_i,
  input  logic [PRIORITY_BITS-1:0]      new_pri_i,
  input  logic                          left_le_i,
  input  logic [sjq_pkg::IdW-1:0]       left_id_i,
  input  logic [PRIORITY_BITS-1:0]      left_pri_i,
  input  logic [sjq_pkg::IdW-1:0]       right_id_i,
  input  logic [PRIORITY_BITS-1:0]      right_pri_i,
  output logic                          le_o,
  output logic [sjq_pkg::IdW-1:0]       id_o,
  output logic [PRIORITY_BITS-1:0]      pri_o
);
  import sjq_pkg::*;

  logic [IdW-1:0]           id_q, id_d;
  logic [PRIORITY_BITS-1:0] pri_q, pri_d;

  // Held job stays ahead of the new one when its number is not larger
  assign le_o = occ_i && (pri_q <= new_pri_i);

  always_comb begin
    id_d  = id_q;
    pri_d = pri_q;
    if (ctrl_i.enq) begin
      if (le_o) begin
        id_d  = id_q;
        pri_d = pri_q;
      end else if (left_le_i) begin
        id_d  = new_id_i;
        pri_d = new_pri_i;
      end else begin
        id_d  = left_id_i;
        pri_d = left_pri_i;
      end
    end else if (ctrl_i.deq) begin
      id_d  = right_id_i;
      pri_d = right_pri_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    pri_q <= pri_d;
  end

  assign id_o  = id_q;
  assign pri_o = pri_q;

endmodule

>>> rtl/core/sorted_priority_job_queue_core.sv
// Top level of the sorted priority job queue: cell chain, occupancy count and response register.
//
// Sorted priority job queue. Holds up to DEPTH jobs (16-bit signed id, nonzero
// priority, 1 most urgent) in a row of cells kept in priority order, most urgent
// in cell 0. Each request transaction is enqueue, dequeue or peek; each produces
// exactly one response transaction carrying the returned job (if any), the
// accepted flag and the count, free space, full and empty status after the
// operation. Enqueue places the job behind all held jobs of equal or smaller
// priority number, so ties leave in arrival order; it is dropped when the queue
// is full or the priority (reduced to PRIORITY_BITS bits) is zero. Peek of a job
// with a negative id reports no job. Every cell compares its priority with the
// incoming one and shifts towards its neighbour in the same cycle, so an
// operation completes in the cycle it is accepted. One request per cycle is
// taken while the response register is empty or being drained; the response
// is registered and valid in the cycle after. The response register is the
// only buffering, so a stalled response stalls the request side.
module sorted_priority_job_queue_core #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sjq_req_if.sink    req_i,
  sjq_rsp_if.source  rsp_o
);
  import sjq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]          count_q, count_d;
  logic                     rsp_valid_q;
  rsp_t                     rsp_q, rsp_d;
  logic                     accept;
  logic                     enq_ok, deq_ok, peek_ok;
  logic [PRIORITY_BITS-1:0] new_pri;
  cell_ctrl_t               ctrl;

  logic [IdW-1:0]           cell_id  [DEPTH];
  logic [PRIORITY_BITS-1:0] cell_pri [DEPTH];
  logic                     cell_le  [DEPTH];

  // Single response register; a new request enters when it is free or draining
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign new_pri = PRIORITY_BITS'(req_i.payload.job_priority);

  always_comb begin
    enq_ok  = 1'b0;
    deq_ok  = 1'b0;
    peek_ok = 1'b0;
    case (req_i.payload.kind)
      KIND_ENQ: begin
        enq_ok = (count_q != CntW'(DEPTH)) && (new_pri != '0);
      end
      KIND_DEQ: begin
        deq_ok = (count_q != '0);
      end
      KIND_PEEK: begin
        // negative id reports nothing
        peek_ok = (count_q != '0) && !cell_id[0][IdW-1];
      end
      default: begin
        enq_ok  = 1'b0;
        deq_ok  = 1'b0;
        peek_ok = 1'b0;
      end
    endcase
  end

  assign ctrl.enq = accept && enq_ok;
  assign ctrl.deq = accept && deq_ok;

  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Chain of cells: cell 0 sees an always-true left flag so it takes the new job
  // when nothing held stays ahead; the last cell shifts in don't-care data.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     left_le;
    logic [IdW-1:0]           left_id;
    logic [PRIORITY_BITS-1:0] left_pri;
    logic [IdW-1:0]           right_id;
    logic [PRIORITY_BITS-1:0] right_pri;

    if (i == 0) begin : g_first
      assign left_le  = 1'b1;
      assign left_id  = req_i.payload.job_id;
      assign left_pri = new_pri;
    end else begin : g_inner
      assign left_le  = cell_le[i-1];
      assign left_id  = cell_id[i-1];
      assign left_pri = cell_pri[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_id  = '0;
      assign right_pri = '0;
    end else begin : g_body
      assign right_id  = cell_id[i+1];
      assign right_pri = cell_pri[i+1];
    end

    sjq_cell #(
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (CntW'(i) < count_q),
      .new_id_i    (req_i.payload.job_id),
      .new_pri_i   (new_pri),
      .left_le_i   (left_le),
      .left_id_i   (left_id),
      .left_pri_i  (left_pri),
      .right_id_i  (right_id),
      .right_pri_i (right_pri),
      .le_o        (cell_le[i]),
      .id_o        (cell_id[i]),
      .pri_o       (cell_pri[i])
    );
  end

  // Response built from the head cell and the post-operation count
  always_comb begin
    rsp_d              = '0;
    rsp_d.job_valid    = deq_ok || peek_ok;
    rsp_d.out_id       = (deq_ok || peek_ok) ? cell_id[0] : '0;
    rsp_d.out_priority = (deq_ok || peek_ok) ? PriPortW'(cell_pri[0]) : '0;
    rsp_d.accepted     = enq_ok;
    rsp_d.entry_count  = CntPortW'(count_d);
    rsp_d.space_left   = CntPortW'(CntW'(DEPTH) - count_d);
    rsp_d.is_full      = (count_d == CntW'(DEPTH));
    rsp_d.is_empty     = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule
